/* rtl/pbm_pkg.sv */
// Shared widths, limits and sequencer states for the profile bin merge block.
`default_nettype none
package pbm_pkg;

	localparam int MUL_W = 32;              // shared multiplier operand width
	localparam int PROD_W = 2 * MUL_W;
	localparam int WS_W = 40;               // weighted sum, signed, 2^-8 units
	localparam int SS_W = 64;               // square sum, unsigned, 2^-16 units
	localparam int ET_W = 22;               // entry total
	localparam int ACC_W = 88;              // signed numerator accumulator
	localparam int DIV_W = 66;              // divisor / partial remainder width
	localparam int QX_W = 32;               // quotient and dividend shift register

	localparam logic [WS_W-1:0] WS_MAX = {1'b0, {(WS_W-1){1'b1}}};
	localparam logic [WS_W-1:0] WS_MIN = {1'b1, {(WS_W-1){1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_A1, ST_A2, ST_A3, ST_A4, ST_A5,
		ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8, ST_F9,
		ST_ECHK, ST_EDIV, ST_SQRT,
		ST_MCHK, ST_MDIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

/* rtl/pbm_mul.sv */
// Shared unsigned multiplier with a registered product.
`default_nettype none
module pbm_mul (
	input  wire logic                         clk,
	input  wire logic [pbm_pkg::MUL_W-1:0]    a,
	input  wire logic [pbm_pkg::MUL_W-1:0]    b,
	output logic      [pbm_pkg::PROD_W-1:0]   p
);

	logic [pbm_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule
`default_nettype wire

/* rtl/profile_bin_merge_mean_error.sv */
// Top level: pooled mean and standard error over a row of profile bins.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | bin_mean, bin_error, bin_count, last_bin
//  out     | output    | out_valid / out_ready| pooled_mean, mean_error, empty_row, saturated
//
// A bin beat is the accept cycle plus five steps that share the single
// 32x32 multiplier (mean*count, error*count, its square, mean^2*count, then the sums).
// A beat marked last then runs nine multiplier steps that build T^3 and
// square_sum*T - weighted_sum^2, then the bit-serial divider runs 32 steps, the root
// 16 steps and the mean division 16 steps; an empty row stops after the first step.
// Reset clears the sums, the sequencer and the output valid flag; no clearing pass.
// in_ready is high only in the idle state; a finished result waits in the output
// register, and the next row's result waits in the done state until that slot frees.
`default_nettype none
module profile_bin_merge_mean_error (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] bin_mean,
	input  wire logic        [15:0] bin_error,
	input  wire logic        [11:0] bin_count,
	input  wire logic               last_bin,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed      [15:0] pooled_mean,
	output logic             [15:0] mean_error,
	output logic                    empty_row,
	output logic                    saturated
);

	localparam int MW = pbm_pkg::MUL_W;
	localparam int PW = pbm_pkg::PROD_W;
	localparam int WW = pbm_pkg::WS_W;
	localparam int SW = pbm_pkg::SS_W;
	localparam int EW = pbm_pkg::ET_W;
	localparam int AW = pbm_pkg::ACC_W;
	localparam int DW = pbm_pkg::DIV_W;
	localparam int QW = pbm_pkg::QX_W;

	pbm_pkg::state_t state_q, state_d;

	// running sums
	logic [WW-1:0] ws_q;
	logic [SW-1:0] ss_q;
	logic [EW-1:0] et_q;
	logic          ovf_q;

	// captured bin
	logic [15:0]   cabs_q;
	logic          cneg_q;
	logic [15:0]   e_q;
	logic [11:0]   n_q;
	logic          last_q;

	// per-bin partial products
	logic [27:0]   cn_q;
	logic [55:0]   term_q;

	// final phase
	logic [11:0]   tth_q;
	logic [AW-1:0] acc_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] qx_q;
	logic [4:0]    cnt_q;
	logic [15:0]   err_q;
	logic [15:0]   mean_q;
	logic          empty_q;

	// output register
	logic          outv_q;
	logic [15:0]   pm_q;
	logic [15:0]   me_q;
	logic          er_q;
	logic          sat_q;

	// multiplier
	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] prod;

	pbm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// combinational datapath
	logic [15:0]   bin_abs;
	logic [WW-1:0] sabs;
	logic          wneg;
	logic [WW:0]   cn_ext, cn_sgn, ws_sum;
	logic          ws_ovf;
	logic [WW-1:0] ws_nx;
	logic [56:0]   term;
	logic [SW:0]   ss_sum;
	logic [SW-1:0] ss_nx;
	logic [EW:0]   et_sum;
	logic [EW-1:0] et_nx;
	logic [AW-1:0] pext;
	logic [AW-1:0] acc_nx;
	logic [97:0]   x_ext, elim;
	logic          ege;
	logic [DW-1:0] dvs;
	logic [DW:0]   r2, rdiff;
	logic          dge;
	logic [DW-1:0] rem_nx;
	logic [QW-1:0] qx_nx;
	logic [QW-1:0] sbit;
	logic [QW:0]   ssum;
	logic          sge;
	logic [QW-1:0] v_nx, res_nx;
	logic [WW:0]   num, mlim;
	logic          msat;
	logic          load;

	function automatic logic [15:0] clamp_mean(input logic sat, input logic [15:0] q,
		input logic neg);
		logic [15:0] r;
		if (neg) begin
			r = (sat || q > 16'd32768) ? 16'h8000 : 16'(-q);
		end else begin
			r = (sat || q > 16'd32767) ? 16'h7FFF : q;
		end
		return r;
	endfunction

	always_comb begin
		bin_abs = bin_mean[15] ? 16'(-bin_mean) : bin_mean;
		wneg    = ws_q[WW-1];
		sabs    = wneg ? WW'(-ws_q) : ws_q;

		// saturating sum updates from the finished per-bin products
		cn_ext  = {{(WW+1-28){1'b0}}, cn_q};
		cn_sgn  = cneg_q ? -cn_ext : cn_ext;
		ws_sum  = {ws_q[WW-1], ws_q} + cn_sgn;
		ws_ovf  = ws_sum[WW] ^ ws_sum[WW-1];
		ws_nx   = ws_ovf ? (ws_sum[WW] ? pbm_pkg::WS_MIN : pbm_pkg::WS_MAX) : ws_sum[WW-1:0];
		term    = {1'b0, term_q} + 57'(prod[43:0]);
		ss_sum  = {1'b0, ss_q} + (SW+1)'(term);
		ss_nx   = ss_sum[SW] ? {SW{1'b1}} : ss_sum[SW-1:0];
		et_sum  = {1'b0, et_q} + (EW+1)'(n_q);
		et_nx   = et_sum[EW] ? {EW{1'b1}} : et_sum[EW-1:0];

		// numerator accumulator: adds and subtracts shifted products
		pext    = {{(AW-PW){1'b0}}, prod};
		acc_nx  = acc_q;
		unique case (state_q)
			pbm_pkg::ST_F3: acc_nx = pext;
			pbm_pkg::ST_F4: acc_nx = acc_q + (pext << 32);
			pbm_pkg::ST_F5: acc_nx = pext;
			pbm_pkg::ST_F6: acc_nx = acc_q + (pext << 32);
			pbm_pkg::ST_F7: acc_nx = acc_q - pext;
			pbm_pkg::ST_F8: acc_nx = acc_q - (pext << 33);
			pbm_pkg::ST_F9: acc_nx = acc_q - (pext << 64);
			default:        acc_nx = acc_q;
		endcase

		// quotient of the variance numerator by T^3 fits 32 bits unless this holds
		x_ext   = {{(98-AW+2){1'b0}}, acc_q[AW-3:0]};
		elim    = {d_q, 32'd0};
		ege     = x_ext >= elim;

		// restoring divide step, shared by both divisions
		dvs     = (state_q == pbm_pkg::ST_MDIV) ? DW'(et_q) : d_q;
		r2      = {rem_q, qx_q[QW-1]};
		rdiff   = r2 - {1'b0, dvs};
		dge     = r2 >= {1'b0, dvs};
		rem_nx  = dge ? rdiff[DW-1:0] : r2[DW-1:0];
		qx_nx   = {qx_q[QW-2:0], dge};

		// square root step: value in rem_q, root in qx_q
		sbit    = QW'(1) << {cnt_q[3:0], 1'b0};
		ssum    = {1'b0, qx_q} + {1'b0, sbit};
		sge     = {1'b0, rem_q[QW-1:0]} >= ssum;
		v_nx    = sge ? rem_q[QW-1:0] - ssum[QW-1:0] : rem_q[QW-1:0];
		res_nx  = sge ? (qx_q >> 1) + sbit : qx_q >> 1;

		// rounded mean: (|sum| + T/2) / T, quotient above 16 bits saturates
		num     = {1'b0, sabs} + (WW+1)'(et_q[EW-1:1]);
		mlim    = {{(WW+1-EW-16){1'b0}}, et_q, 16'd0};
		msat    = num >= mlim;

		load    = (state_q == pbm_pkg::ST_DONE) && (!outv_q || out_ready);

		// multiplier operands
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			pbm_pkg::ST_A1: begin mul_a = MW'(cabs_q);      mul_b = MW'(n_q); end
			pbm_pkg::ST_A2: begin mul_a = MW'(e_q);         mul_b = MW'(n_q); end
			pbm_pkg::ST_A3: begin mul_a = MW'(prod[27:0]);  mul_b = MW'(prod[27:0]); end
			pbm_pkg::ST_A4: begin mul_a = MW'(cabs_q);      mul_b = MW'(cn_q); end
			pbm_pkg::ST_F1: begin mul_a = MW'(et_q);        mul_b = MW'(et_q); end
			pbm_pkg::ST_F2: begin mul_a = prod[31:0];       mul_b = MW'(et_q); end
			pbm_pkg::ST_F3: begin mul_a = MW'(tth_q);       mul_b = MW'(et_q); end
			pbm_pkg::ST_F4: begin mul_a = ss_q[31:0];       mul_b = MW'(et_q); end
			pbm_pkg::ST_F5: begin mul_a = ss_q[63:32];      mul_b = MW'(et_q); end
			pbm_pkg::ST_F6: begin mul_a = sabs[31:0];       mul_b = sabs[31:0]; end
			pbm_pkg::ST_F7: begin mul_a = sabs[31:0];       mul_b = MW'(sabs[39:32]); end
			pbm_pkg::ST_F8: begin mul_a = MW'(sabs[39:32]); mul_b = MW'(sabs[39:32]); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbm_pkg::ST_IDLE: if (in_valid) state_d = pbm_pkg::ST_A1;
			pbm_pkg::ST_A1:   state_d = pbm_pkg::ST_A2;
			pbm_pkg::ST_A2:   state_d = pbm_pkg::ST_A3;
			pbm_pkg::ST_A3:   state_d = pbm_pkg::ST_A4;
			pbm_pkg::ST_A4:   state_d = pbm_pkg::ST_A5;
			pbm_pkg::ST_A5:   state_d = last_q ? pbm_pkg::ST_F1 : pbm_pkg::ST_IDLE;
			pbm_pkg::ST_F1:   state_d = (et_q == '0) ? pbm_pkg::ST_DONE : pbm_pkg::ST_F2;
			pbm_pkg::ST_F2:   state_d = pbm_pkg::ST_F3;
			pbm_pkg::ST_F3:   state_d = pbm_pkg::ST_F4;
			pbm_pkg::ST_F4:   state_d = pbm_pkg::ST_F5;
			pbm_pkg::ST_F5:   state_d = pbm_pkg::ST_F6;
			pbm_pkg::ST_F6:   state_d = pbm_pkg::ST_F7;
			pbm_pkg::ST_F7:   state_d = pbm_pkg::ST_F8;
			pbm_pkg::ST_F8:   state_d = pbm_pkg::ST_F9;
			pbm_pkg::ST_F9:   state_d = pbm_pkg::ST_ECHK;
			pbm_pkg::ST_ECHK: state_d = (acc_q[AW-1] || ege) ? pbm_pkg::ST_MCHK
				: pbm_pkg::ST_EDIV;
			pbm_pkg::ST_EDIV: if (cnt_q == '0) state_d = pbm_pkg::ST_SQRT;
			pbm_pkg::ST_SQRT: if (cnt_q == '0) state_d = pbm_pkg::ST_MCHK;
			pbm_pkg::ST_MCHK: state_d = msat ? pbm_pkg::ST_DONE : pbm_pkg::ST_MDIV;
			pbm_pkg::ST_MDIV: if (cnt_q == '0) state_d = pbm_pkg::ST_DONE;
			pbm_pkg::ST_DONE: if (!outv_q || out_ready) state_d = pbm_pkg::ST_IDLE;
			default:          state_d = pbm_pkg::ST_IDLE;
		endcase
	end

	// control state and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbm_pkg::ST_IDLE;
			outv_q  <= 1'b0;
			ws_q    <= '0;
			ss_q    <= '0;
			et_q    <= '0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				outv_q <= 1'b1;
			end else if (out_ready) begin
				outv_q <= 1'b0;
			end
			if (state_q == pbm_pkg::ST_A5) begin
				ws_q  <= ws_nx;
				ss_q  <= ss_nx;
				et_q  <= et_nx;
				ovf_q <= ovf_q | ws_ovf | ss_sum[SW] | et_sum[EW];
			end else if (load) begin
				// clear the sums for the next row
				ws_q  <= '0;
				ss_q  <= '0;
				et_q  <= '0;
				ovf_q <= 1'b0;
			end
			unique case (state_q)
				pbm_pkg::ST_ECHK: cnt_q <= 5'(QW - 1);
				pbm_pkg::ST_EDIV: cnt_q <= (cnt_q == '0) ? 5'(QW / 2 - 1) : cnt_q - 5'd1;
				pbm_pkg::ST_MCHK: cnt_q <= 5'd15;
				pbm_pkg::ST_SQRT,
				pbm_pkg::ST_MDIV: cnt_q <= cnt_q - 5'd1;
				default:          cnt_q <= cnt_q;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			pbm_pkg::ST_IDLE: begin
				if (in_valid) begin
					cabs_q <= bin_abs;
					cneg_q <= bin_mean[15];
					e_q    <= bin_error;
					n_q    <= bin_count;
					last_q <= last_bin;
				end
			end
			pbm_pkg::ST_A2: cn_q   <= prod[27:0];
			pbm_pkg::ST_A4: term_q <= prod[55:0];
			pbm_pkg::ST_F1: begin
				empty_q <= (et_q == '0);
				mean_q  <= '0;
				err_q   <= '0;
			end
			pbm_pkg::ST_F2: tth_q <= prod[43:32];
			pbm_pkg::ST_F3, pbm_pkg::ST_F4, pbm_pkg::ST_F6, pbm_pkg::ST_F7,
			pbm_pkg::ST_F8, pbm_pkg::ST_F9: acc_q <= acc_nx;
			pbm_pkg::ST_F5: begin
				d_q   <= acc_q[DW-1:0];
				acc_q <= acc_nx;
			end
			pbm_pkg::ST_ECHK: begin
				// negative numerator: error stays zero; oversize quotient: saturate
				if (acc_q[AW-1]) begin
					err_q <= '0;
				end else if (ege) begin
					err_q <= 16'hFFFF;
				end else begin
					rem_q <= DW'(acc_q[AW-3:32]);
					qx_q  <= acc_q[31:0];
				end
			end
			pbm_pkg::ST_EDIV: begin
				if (cnt_q == '0) begin
					// hand the quotient to the root step
					rem_q <= DW'(qx_nx);
					qx_q  <= '0;
				end else begin
					rem_q <= rem_nx;
					qx_q  <= qx_nx;
				end
			end
			pbm_pkg::ST_SQRT: begin
				rem_q <= DW'(v_nx);
				qx_q  <= res_nx;
				if (cnt_q == '0) err_q <= res_nx[15:0];
			end
			pbm_pkg::ST_MCHK: begin
				if (msat) begin
					mean_q <= clamp_mean(1'b1, 16'd0, wneg);
				end else begin
					rem_q <= DW'(num[WW:16]);
					qx_q  <= {num[15:0], 16'd0};
				end
			end
			pbm_pkg::ST_MDIV: begin
				rem_q <= rem_nx;
				qx_q  <= qx_nx;
				if (cnt_q == '0) mean_q <= clamp_mean(1'b0, qx_nx[15:0], wneg);
			end
			pbm_pkg::ST_DONE: begin
				if (load) begin
					pm_q  <= mean_q;
					me_q  <= err_q;
					er_q  <= empty_q;
					sat_q <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready    = (state_q == pbm_pkg::ST_IDLE);
	assign out_valid   = outv_q;
	assign pooled_mean = pm_q;
	assign mean_error  = me_q;
	assign empty_row   = er_q;
	assign saturated   = sat_q;

`ifndef SYNTH
	// a result appears only out of the done state
	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == pbm_pkg::ST_DONE))
		else $error("result raised outside the done state");

	// loading a result clears every sum
	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (ws_q == '0 && ss_q == '0 && et_q == '0 && !ovf_q && out_valid))
		else $error("sums not cleared after result");

	// an empty row carries zero mean and zero error
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_row) |-> (pooled_mean == 16'sd0 && mean_error == 16'd0))
		else $error("empty row with nonzero result");
`endif

endmodule
`default_nettype wire
